[src/adrc_pkg.sv]
package adrc_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int CHANNELS_DEF    = 8;
    localparam int CH_BITS         = 3;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 20;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAKEUP    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE   = 3'd4;

    localparam logic [16:0] UNITY_GAIN  = 17'd65536;
    localparam logic [15:0] DB_FLOOR    = 16'd30720;
    localparam logic [19:0] DB_PER_LOG2 = 20'd394566;
    localparam logic [13:0] LOG2_TEN_20 = 14'd10885;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] sample_in;
        logic [CH_BITS-1:0]                channel;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] sample_out;
        logic [CH_BITS-1:0]                channel_out;
    } out_item_t;

    // datapath step selects
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_LOG_SQ,
        OP_LEVEL,
        OP_RED,
        OP_EXPO,
        OP_EXP_STEP,
        OP_TARGET,
        OP_ENV_MUL,
        OP_ENV_UPD,
        OP_OUT_MUL1,
        OP_OUT_MUL2,
        OP_NONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] step;
    } dp_cmd_t;

    function automatic logic [15:0] exp_step(input logic [3:0] k);
        logic [15:0] r;
        begin
            case (k)
                4'd0:    r = 16'd46341;
                4'd1:    r = 16'd55109;
                4'd2:    r = 16'd60097;
                4'd3:    r = 16'd62757;
                4'd4:    r = 16'd64132;
                4'd5:    r = 16'd64830;
                4'd6:    r = 16'd65182;
                4'd7:    r = 16'd65359;
                4'd8:    r = 16'd65447;
                4'd9:    r = 16'd65492;
                4'd10:   r = 16'd65514;
                4'd11:   r = 16'd65525;
                default: r = 16'd65535;
            endcase
            return r;
        end
    endfunction

endpackage

[src/adrc_ctrl.sv]
module adrc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output adrc_pkg::dp_cmd_t cmd
);
    import adrc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_LOG    = 11'b00000000010,
        S_LEVEL  = 11'b00000000100,
        S_RED    = 11'b00000001000,
        S_EXPO   = 11'b00000010000,
        S_EXP    = 11'b00000100000,
        S_TGT    = 11'b00001000000,
        S_ENVM   = 11'b00010000000,
        S_ENVU   = 11'b00100000000,
        S_OUT1   = 11'b01000000000,
        S_OUT2   = 11'b10000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;

    // accept while idle; result register frees independently
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.step       = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_LOG;
                    step_next  = 4'd0;
                end
            end
            S_LOG:
            begin
                cmd.op    = OP_LOG_SQ;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd11)
                    state_next = S_LEVEL;
            end
            S_LEVEL: begin cmd.op = OP_LEVEL; state_next = S_RED; end
            S_RED:   begin cmd.op = OP_RED;   state_next = S_EXPO; end
            S_EXPO:
            begin
                cmd.op     = OP_EXPO;
                state_next = S_EXP;
                step_next  = 4'd0;
            end
            S_EXP:
            begin
                cmd.op    = OP_EXP_STEP;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd11)
                    state_next = S_TGT;
            end
            S_TGT:   begin cmd.op = OP_TARGET;  state_next = S_ENVM; end
            S_ENVM:  begin cmd.op = OP_ENV_MUL; state_next = S_ENVU; end
            S_ENVU:  begin cmd.op = OP_ENV_UPD; state_next = S_OUT1; end
            S_OUT1:  begin cmd.op = OP_OUT_MUL1; state_next = S_OUT2; end
            S_OUT2:
            begin
                // wait until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT_MUL2;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/adrc_dp.sv]
module adrc_dp #(
    parameter int CHANNELS = adrc_pkg::CHANNELS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  adrc_pkg::dp_cmd_t                          cmd,
    input  logic signed [adrc_pkg::SAMPLE_BITS_DEF-1:0] sample_in,
    input  logic [adrc_pkg::CH_BITS-1:0]               channel,
    input  logic signed [15:0]                         threshold_db,
    input  logic [15:0]                                comp_slope,
    input  logic [19:0]                                makeup_gain,
    input  logic [15:0]                                attack_coeff,
    input  logic [15:0]                                release_coeff,
    output logic signed [adrc_pkg::SAMPLE_BITS_DEF-1:0] sample_out,
    output logic [adrc_pkg::CH_BITS-1:0]               channel_out
);
    import adrc_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAG_BITS = SAMPLE_BITS;
    localparam int P_BITS   = $clog2(SAMPLE_BITS);
    localparam logic [MAG_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic [16:0]         env_reg [CHANNELS];
    logic [CHANNELS-1:0] env_vld_reg;

    logic [MAG_BITS-1:0]  mag_reg;
    logic                 neg_reg;
    logic [CH_BITS-1:0]   ch_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic [P_BITS-1:0]    p_reg;
    logic [24:0]          m_reg;
    logic [11:0]          frac_reg;
    logic signed [16:0]   lvl_reg;
    logic [15:0]          red_reg;
    logic [4:0]           n_reg;
    logic [11:0]          f_reg;
    logic [16:0]          g_reg;
    logic [16:0]          tgt_reg;
    logic [16:0]          env_cur_reg;
    logic [16:0]          env_rd_reg;
    logic [16:0]          diff_reg;
    logic                 fall_reg;
    logic [MAG_BITS:0]    y_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic [CH_BITS-1:0]   ch_out_reg;

    // leading-one position and normalized mantissa
    logic [P_BITS-1:0]   lead;
    logic [24:0]         norm;
    logic [MAG_BITS-1:0] mag_in;
    logic                neg_in;
    always_comb
    begin
        neg_in = sample_in[SAMPLE_BITS-1];
        mag_in = neg_in ? (~sample_in + 1'b1) : sample_in;
        lead   = '0;
        for (int i = 0; i < MAG_BITS; i++)
            if (mag_in[i])
                lead = P_BITS'(i);
        if (lead >= P_BITS'(23))
            norm = 25'(mag_in >> (lead - P_BITS'(23)));
        else
            norm = 25'({mag_in, 23'd0} >> lead);
    end

    // channel folded onto the envelope slots
    logic [IDX_BITS-1:0] idx_in;
    always_comb
    begin
        idx_in = '0;
        for (int i = 0; i < 2**CH_BITS; i++)
            if (channel == CH_BITS'(i))
                idx_in = IDX_BITS'(i % CHANNELS);
    end

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_LOG_SQ:   begin mul_a = 32'(m_reg[24:0]); mul_b = 32'(m_reg); end
            OP_LEVEL:    begin mul_a = 32'(17'd94208 - 17'({p_reg, 12'd0}) - 17'(frac_reg));
                               mul_b = 32'(DB_PER_LOG2); end
            OP_RED:      begin mul_a = 32'(17'(lvl_reg - 17'(threshold_db)));
                               mul_b = 32'(comp_slope); end
            OP_EXPO:     begin mul_a = 32'(red_reg); mul_b = 32'(LOG2_TEN_20); end
            OP_EXP_STEP: begin mul_a = 32'(g_reg); mul_b = 32'(exp_step(cmd.step)); end
            OP_ENV_MUL:  begin mul_a = 32'(diff_reg);
                               mul_b = fall_reg ? 32'(attack_coeff) : 32'(release_coeff); end
            OP_OUT_MUL1: begin mul_a = 32'(mag_reg); mul_b = 32'(env_cur_reg); end
            OP_OUT_MUL2: begin mul_a = 32'(y_reg); mul_b = 32'(makeup_gain); end
            default:     begin mul_a = '0; mul_b = '0; end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    logic [63:0] sq;
    logic [16:0] env_sel;
    logic [63:0] neg_db;
    logic [63:0] rnd2;
    logic [63:0] ysat;
    always_comb
    begin
        sq      = prod >> 23;
        env_sel = env_vld_reg[idx_reg] ? env_rd_reg : UNITY_GAIN;
        if (env_sel > UNITY_GAIN)
            env_sel = UNITY_GAIN;
        neg_db  = (prod + 64'd524288) >> 20;
        rnd2    = (prod + 64'd32768) >> 16;
        ysat    = neg_reg ? ((rnd2 > 64'(SMAX) + 64'd1) ? 64'(SMAX) + 64'd1 : rnd2)
                          : ((rnd2 > 64'(SMAX)) ? 64'(SMAX) : rnd2);
    end

    // envelope valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            env_vld_reg <= '0;
        else if (cmd.op == OP_ENV_UPD)
            env_vld_reg[idx_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mag_reg  <= mag_in;
                neg_reg  <= neg_in;
                ch_reg   <= channel;
                idx_reg  <= idx_in;
                p_reg    <= lead;
                m_reg    <= norm;
                frac_reg <= '0;
            end
            OP_LOG_SQ:
            begin
                if (sq[24])
                begin
                    frac_reg <= {frac_reg[10:0], 1'b1};
                    m_reg    <= 25'(sq >> 1);
                end
                else
                begin
                    frac_reg <= {frac_reg[10:0], 1'b0};
                    m_reg    <= sq[24:0];
                end
            end
            OP_LEVEL:
            begin
                if (mag_reg == '0 || neg_db > 64'(DB_FLOOR))
                    lvl_reg <= -17'(DB_FLOOR);
                else
                    lvl_reg <= -17'(neg_db);
            end
            OP_RED:
            begin
                red_reg    <= (lvl_reg > 17'(threshold_db)) ? prod[31:16] : 16'd0;
                env_rd_reg <= env_reg[idx_reg];
            end
            OP_EXPO:
            begin
                n_reg <= (prod[35:24] > 12'd16) ? 5'd17 : 5'(prod[35:24]);
                f_reg <= prod[23:12];
                g_reg <= UNITY_GAIN;
            end
            OP_EXP_STEP:
                if (f_reg[4'd11 - cmd.step])
                    g_reg <= rnd2[16:0];
            OP_TARGET:
            begin
                tgt_reg     <= (n_reg > 5'd16) ? 17'd0 : (g_reg >> n_reg);
                env_cur_reg <= env_sel;
                if ((n_reg > 5'd16 ? 17'd0 : (g_reg >> n_reg)) < env_sel)
                begin
                    fall_reg <= 1'b1;
                    diff_reg <= env_sel - ((n_reg > 5'd16) ? 17'd0 : (g_reg >> n_reg));
                end
                else
                begin
                    fall_reg <= 1'b0;
                    diff_reg <= ((n_reg > 5'd16) ? 17'd0 : (g_reg >> n_reg)) - env_sel;
                end
            end
            OP_ENV_MUL:
                diff_reg <= prod[32:16];
            OP_ENV_UPD:
            begin
                env_cur_reg <= fall_reg ? tgt_reg + diff_reg : tgt_reg - diff_reg;
                env_reg[idx_reg] <= fall_reg ? tgt_reg + diff_reg : tgt_reg - diff_reg;
            end
            OP_OUT_MUL1:
                y_reg <= (MAG_BITS+1)'(rnd2);
            OP_OUT_MUL2:
            begin
                out_reg    <= neg_reg ? SAMPLE_BITS'(-ysat) : SAMPLE_BITS'(ysat);
                ch_out_reg <= ch_reg;
            end
            default: ;
        endcase
    end

    assign sample_out  = out_reg;
    assign channel_out = ch_out_reg;

endmodule

[src/audio_dynamic_range_compressor_top.sv]
// feed-forward hard-knee compressor for interleaved audio channels
// input channel: in_valid/in_ready carry one beat of sample and channel number
// output channel: out_valid/out_ready carry one beat of compressed sample
// one result per input beat, in order
// a new beat waits until the previous beat has left its last step, as the shared
// multiplier runs twelve log squarings and twelve exponent steps in sequence
// registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while idle, the block itself does not enforce this
// reset: registers to defaults, all channel envelopes to unity gain
// the result register holds its beat while out_ready is low; the next beat is
// taken meanwhile and its last step waits for the register to free
module audio_dynamic_range_compressor_top #(
    parameter int CHANNELS = adrc_pkg::CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  adrc_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output adrc_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [adrc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [adrc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import adrc_pkg::*;

    logic signed [15:0] threshold_reg;
    logic [15:0]        slope_reg;
    logic [19:0]        makeup_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;
    dp_cmd_t            cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            slope_reg     <= '0;
            makeup_reg    <= 20'(UNITY_GAIN);
            attack_reg    <= '0;
            release_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[15:0];
                REG_SLOPE:     slope_reg     <= cfg_data[15:0];
                REG_MAKEUP:    makeup_reg    <= cfg_data;
                REG_ATTACK:    attack_reg    <= cfg_data[15:0];
                REG_RELEASE:   release_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    adrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    adrc_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample_in     (in_data.sample_in),
        .channel       (in_data.channel),
        .threshold_db  (threshold_reg),
        .comp_slope    (slope_reg),
        .makeup_gain   (makeup_reg),
        .attack_coeff  (attack_reg),
        .release_coeff (release_reg),
        .sample_out    (out_data.sample_out),
        .channel_out   (out_data.channel_out)
    );

    // a beat is only loaded when taken at the input
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> (in_valid && in_ready))
        else $error("datapath loaded without input beat");

    // result register never overwritten while held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> (cmd.op != OP_OUT_MUL2))
        else $error("held result overwritten");

    // a finished result appears valid next cycle
    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT_MUL2) |=> out_valid)
        else $error("result not presented");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import adrc_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int CHANNELS    = CHANNELS_DEF;
    localparam int RANDOM_BEATS = 1400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    in_item_t                 in_data;
    logic                     out_valid;
    logic                     out_ready;
    out_item_t                out_data;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    audio_dynamic_range_compressor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state and register shadow
    logic signed [15:0] threshold_q;
    logic [15:0]        slope_q;
    logic [19:0]        makeup_q;
    logic [15:0]        attack_q;
    logic [15:0]        release_q;
    logic [16:0]        env_q [CHANNELS];

    in_item_t  sample_queue [$];
    out_item_t compressed_queue [$];

    int  mismatches;
    int  stall_cycles;
    int  beats_in;
    int  beats_out;
    int  saturated_beats;
    bit  idle_enable;
    bit  sender_hold;
    bit  timed_out;

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // base-2 log of the magnitude in Q12
    function automatic logic [31:0] log2_q12(input logic [63:0] mag);
        logic [31:0] lead;
        logic [63:0] m;
        logic [31:0] frac;
        lead = 0;
        frac = 0;
        for (int b = 0; b < 64; b++)
        begin
            if (mag[b])
                lead = b;
        end
        m = (lead >= 23) ? (mag >> (lead - 23)) : (mag << (23 - lead));
        for (int i = 0; i < 12; i++)
        begin
            m = (m * m) >> 23;
            frac = frac << 1;
            if (m >= 64'd16777216)
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return lead * 4096 + frac;
    endfunction

    // level in Q8.8 dB, floored at -120 dB
    function automatic logic signed [31:0] level_db(input logic [63:0] mag);
        logic [63:0] d;
        logic [63:0] neg;
        if (mag == 0)
            return -32'sd30720;
        d = 64'((SAMPLE_BITS - 1) * 4096 - log2_q12(mag));
        neg = (d * 64'd394566 + 64'd524288) >> 20;
        if (neg > 30720)
            neg = 30720;
        return -$signed(neg[31:0]);
    endfunction

    // linear gain from a reduction in dB
    function automatic logic [31:0] gain_of_reduction(input logic [31:0] red);
        logic [63:0] e;
        logic [63:0] n;
        logic [11:0] f;
        logic [63:0] g;
        logic [15:0] steps [12];
        steps = '{46341, 55109, 60097, 62757, 64132, 64830,
                  65182, 65359, 65447, 65492, 65514, 65525};
        e = ({32'd0, red} * 64'd10885) >> 12;
        n = e >> 12;
        f = e[11:0];
        g = 65536;
        for (int k = 0; k < 12; k++)
        begin
            if (f[11 - k])
                g = (g * steps[k] + 64'd32768) >> 16;
        end
        if (n > 16)
            return 0;
        return 32'(g >> n);
    endfunction

    // compress one sample and advance the channel envelope
    function automatic out_item_t compress_sample(input in_item_t item);
        out_item_t          res;
        logic [63:0]        raw;
        logic               neg;
        logic [63:0]        mag;
        logic signed [31:0] lvl;
        logic [31:0]        red;
        logic [31:0]        tgt;
        logic [31:0]        env;
        logic [63:0]        y;
        int                 ch;
        raw = {40'd0, item.sample_in};
        neg = item.sample_in[SAMPLE_BITS-1];
        mag = neg ? ((64'd1 << SAMPLE_BITS) - raw) : raw;
        lvl = level_db(mag);
        red = 0;
        if (lvl > threshold_q)
            red = 32'((64'(lvl - threshold_q) * slope_q) >> 16);
        tgt = gain_of_reduction(red);
        ch = item.channel % CHANNELS;
        env = env_q[ch];
        if (env > 65536)
            env = 65536;
        if (tgt < env)
            env = tgt + 32'((64'(env - tgt) * attack_q) >> 16);
        else
            env = tgt - 32'((64'(tgt - env) * release_q) >> 16);
        env_q[ch] = env[16:0];
        y = (mag * env + 64'd32768) >> 16;
        y = (y * makeup_q + 64'd32768) >> 16;
        if (neg)
            res.sample_out = (y > 64'd8388608) ? 24'h800000 : 24'(-y);
        else
            res.sample_out = (y > 64'd8388607) ? 24'h7fffff : 24'(y);
        if (y > 64'd8388607)
            saturated_beats++;
        res.channel_out = item.channel;
        return res;
    endfunction

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_THRESHOLD: threshold_q = val[15:0];
            REG_SLOPE:     slope_q     = val[15:0];
            REG_MAKEUP:    makeup_q    = val;
            REG_ATTACK:    attack_q    = val[15:0];
            REG_RELEASE:   release_q   = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [15:0] thr, input logic [15:0] slope,
                             input logic [19:0] makeup, input logic [15:0] att,
                             input logic [15:0] rel);
        write_reg(REG_THRESHOLD, {4'd0, thr});
        write_reg(REG_SLOPE, {4'd0, slope});
        write_reg(REG_MAKEUP, makeup);
        write_reg(REG_ATTACK, {4'd0, att});
        write_reg(REG_RELEASE, {4'd0, rel});
    endtask

    // wait until the block has drained all outstanding beats
    task automatic wait_drained();
        while (sample_queue.size() != 0 || compressed_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic in_item_t rand_sample();
        in_item_t it;
        case ($urandom_range(0, 9))
            0: it.sample_in = 24'($urandom_range(0, 255));
            1: it.sample_in = -$signed(24'($urandom_range(0, 255)));
            2: it.sample_in = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            3: it.sample_in = 24'($urandom) >>> $urandom_range(0, 23);
            default: it.sample_in = 24'($urandom);
        endcase
        it.channel = 3'($urandom_range(0, CHANNELS - 1));
        return it;
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            sample_queue.push_back(rand_sample());
        wait_drained();
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                compressed_queue.push_back(compress_sample(in_data));
                beats_in++;
                void'(sample_queue.pop_front());
            end
            if ((!in_valid || in_ready) && !sender_hold)
            begin
                // the front of the queue is the next pending sample
                if (sample_queue.size() != 0
                    && !(idle_enable && $urandom_range(0, 99) < 8))
                begin
                    in_valid <= 1'b1;
                    in_data  <= sample_queue[0];
                end
                else
                    in_valid <= 1'b0;
            end
            else if (in_valid && in_ready)
                in_valid <= 1'b0;
        end
    end

    // output monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            out_ready <= !(idle_enable && $urandom_range(0, 99) < 8);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (compressed_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: sample %0d channel %0d",
                                 out_data.sample_out, out_data.channel_out);
                end
                else
                begin
                    out_item_t exp_item;
                    exp_item = compressed_queue.pop_front();
                    if (exp_item.sample_out !== out_data.sample_out
                        || exp_item.channel_out !== out_data.channel_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d ch %0d, got %0d ch %0d",
                                     exp_item.sample_out, exp_item.channel_out,
                                     out_data.sample_out, out_data.channel_out);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("timeout after %0d quiet cycles", stall_cycles);
            $display("FAIL audio_dynamic_range_compressor_top");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        in_item_t it;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        mismatches  = 0;
        beats_in    = 0;
        beats_out   = 0;
        saturated_beats = 0;
        idle_enable = 1'b1;
        sender_hold = 1'b0;
        timed_out   = 1'b0;
        threshold_q = 0;
        slope_q     = 0;
        makeup_q    = 20'd65536;
        attack_q    = 0;
        release_q   = 0;
        for (int c = 0; c < CHANNELS; c++)
            env_q[c] = UNITY_GAIN;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults pass samples straight through
        it.channel = 0;
        it.sample_in = 24'sd0;        sample_queue.push_back(it);
        it.sample_in = 24'sd1;        sample_queue.push_back(it);
        it.sample_in = -24'sd1;       sample_queue.push_back(it);
        it.sample_in = 24'h7fffff;    it.channel = 7; sample_queue.push_back(it);
        it.sample_in = 24'h800000;    it.channel = 3; sample_queue.push_back(it);
        wait_drained();

        // directed: heavy compression, threshold at -120 dB, big makeup
        write_all(16'h8800, 16'hffff, 20'hfffff, 16'd0, 16'd0);
        for (int c = 0; c < CHANNELS; c++)
        begin
            it.channel = 3'(c);
            it.sample_in = (c % 2) ? 24'h800000 : 24'h7fffff;
            sample_queue.push_back(it);
            it.sample_in = 24'sd0;
            sample_queue.push_back(it);
        end
        it.sample_in = 24'sd3; it.channel = 5; sample_queue.push_back(it);
        wait_drained();

        // directed: slow attack and release, threshold below the floor
        write_all(16'h8000, 16'h8000, 20'd0, 16'hffff, 16'hffff);
        it.sample_in = 24'h400000; it.channel = 1; sample_queue.push_back(it);
        it.sample_in = 24'h000010; it.channel = 1; sample_queue.push_back(it);
        wait_drained();

        // random phases over a range of settings
        write_all(16'hf400, 16'hc000, 20'h20000, 16'hf000, 16'hff00);
        idle_enable = 1'b0;
        queue_random(200);
        idle_enable = 1'b1;
        queue_random(300);

        // hold the sender until every result has come back
        sender_hold = 1'b1;
        for (int i = 0; i < 40; i++)
            sample_queue.push_back(rand_sample());
        while (compressed_queue.size() != 0 || in_valid)
            @(posedge clk);
        sender_hold = 1'b0;
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            write_all(16'(-$urandom_range(0, 30720)), 16'($urandom),
                      20'($urandom_range(0, 20'hfffff)), 16'($urandom), 16'($urandom));
            write_reg(CFG_IDX_BITS'(5 + $urandom_range(0, 2)), 20'($urandom));
            queue_random(215);
        end

        $display("covered %0d beats in, %0d out, %0d saturated, across eight register",
                 beats_in, beats_out, saturated_beats);
        $display("settings with writes to unused indexes and a held sender");
        if (mismatches == 0 && compressed_queue.size() == 0)
            $display("PASS audio_dynamic_range_compressor_top");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     compressed_queue.size());
            $display("FAIL audio_dynamic_range_compressor_top");
        end
        $finish;
    end

endmodule
